@@ hw/rtl/chbd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chbd_pkg
// shared types and constants of the chunked body decoder
// ----------------------------------------------------------------------------
package chbd_pkg;

   localparam int REPORT_BITS = 32;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   // trailer bytes dropped after each chunk
   localparam logic [1:0] TRAILER_DROP = 2'd2;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_END   = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   // control from the decoder engine to the length counter
   typedef struct packed {
      logic clear;
      logic incr;
   } len_ctl_type;

endpackage

@@ hw/rtl/http_chunked_body_decoder.sv @@
`timescale 1ns / 1ps
// a result is registered and presented in the cycle after the transaction that causes it
// throughput: one body byte per cycle while the result register is empty or rsp_ready is high
// the result register empties and refills in the same cycle when rsp_ready is high
// reset: synchronous, clears framing state, length counter and the result valid
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// decodes an http/1 chunked body into payload bytes plus end and error results
// ----------------------------------------------------------------------------
module http_chunked_body_decoder #(
   parameter int SIZE_CHARS  = 9,
   parameter int LENGTH_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_new_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_body_length
);

   chbd_pkg::len_ctl_type                len_ctl;
   logic [chbd_pkg::REPORT_BITS-1:0]     report_len;
   logic                                 accept;

   // take a transaction whenever the result register is empty or draining
   assign req_ready = !rsp_valid || rsp_ready;
   assign accept    = req_valid && req_ready;

   // running payload length, saturating at the counter width
   chbd_length_counter #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_len (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .ctl        (len_ctl),
      .report_len (report_len)
   );

   // size line parse, payload pass-through, trailer drop, halt
   chbd_engine #(
      .SIZE_CHARS (SIZE_CHARS)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .rsp_ready       (rsp_ready),
      .in_byte         (req_in_byte),
      .new_message     (req_new_message),
      .report_len      (report_len),
      .len_ctl         (len_ctl),
      .rsp_valid       (rsp_valid),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_kind        (rsp_kind),
      .rsp_body_length (rsp_body_length)
   );

endmodule

@@ hw/rtl/chbd_hex_digit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chbd_hex_digit
// ascii hex digit decoder, both letter cases
// ----------------------------------------------------------------------------
module chbd_hex_digit (
   input  logic [7:0] char_in,
   output logic       digit_valid,
   output logic [3:0] digit_value
);

   logic [7:0] off_num;
   logic [7:0] off_low;
   logic [7:0] off_up;

   always_comb begin
      off_num     = char_in - 8'h30;
      off_low     = char_in - 8'h61;
      off_up      = char_in - 8'h41;
      digit_valid = 1'b1;
      digit_value = 4'd0;
      if (char_in >= 8'h30 && char_in <= 8'h39) begin
         digit_value = off_num[3:0];
      end else if (char_in >= 8'h61 && char_in <= 8'h66) begin
         digit_value = off_low[3:0] + 4'd10;
      end else if (char_in >= 8'h41 && char_in <= 8'h46) begin
         digit_value = off_up[3:0] + 4'd10;
      end else begin
         digit_valid = 1'b0;
      end
   end

endmodule

@@ hw/rtl/chbd_length_counter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chbd_length_counter
// saturating payload byte counter with a 32-bit saturated report
// ----------------------------------------------------------------------------
module chbd_length_counter #(
   parameter int LENGTH_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  chbd_pkg::len_ctl_type               ctl,
   output logic [chbd_pkg::REPORT_BITS-1:0]    report_len
);

   logic [LENGTH_BITS-1:0] total_ff;
   logic [LENGTH_BITS-1:0] total_in;
   logic [LENGTH_BITS-1:0] base;

   always_comb begin
      base     = ctl.clear ? '0 : total_ff;
      total_in = base;
      if (ctl.incr && !(&base)) begin
         total_in = base + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (accept) begin
         total_ff <= total_in;
      end
   end

   // report reflects the value after this transaction
   generate
      if (LENGTH_BITS > chbd_pkg::REPORT_BITS) begin : g_sat
         assign report_len = (|total_in[LENGTH_BITS-1:chbd_pkg::REPORT_BITS]) ? '1 :
                             total_in[chbd_pkg::REPORT_BITS-1:0];
      end else begin : g_ext
         assign report_len = chbd_pkg::REPORT_BITS'(total_in);
      end
   endgenerate

endmodule

@@ hw/rtl/chbd_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chbd_engine
// chunk framing state machine with the result register
// ----------------------------------------------------------------------------
module chbd_engine #(
   parameter int SIZE_CHARS = 9
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic                               rsp_ready,
   input  logic [7:0]                         in_byte,
   input  logic                               new_message,
   input  logic [chbd_pkg::REPORT_BITS-1:0]   report_len,
   output chbd_pkg::len_ctl_type              len_ctl,
   output logic                               rsp_valid,
   output logic [7:0]                         rsp_out_byte,
   output logic [1:0]                         rsp_kind,
   output logic [chbd_pkg::REPORT_BITS-1:0]   rsp_body_length
);

   localparam int CNT_W  = 4 * SIZE_CHARS;
   localparam int SEEN_W = $clog2(SIZE_CHARS + 1);

   typedef enum logic [2:0] {
      PH_SIZE    = 3'd0,
      PH_AFTER   = 3'd1,
      PH_PAYLOAD = 3'd2,
      PH_TRAILER = 3'd3,
      PH_HALT    = 3'd4
   } phase_type;

   phase_type          phase_ff,   phase_in,   cur_phase;
   logic [CNT_W-1:0]   rem_ff,     rem_in,     cur_rem;
   logic [SEEN_W-1:0]  seen_ff,    seen_in,    cur_seen;
   logic               stopped_ff, stopped_in, cur_stopped;
   logic [1:0]         drop_ff,    drop_in,    cur_drop;
   logic               valid_ff,   valid_in;
   logic [7:0]         byte_ff,    byte_in;
   chbd_pkg::kind_type kind_ff,    kind_in;
   logic [chbd_pkg::REPORT_BITS-1:0] len_ff, len_in;
   logic               res_valid;
   logic               digit_valid;
   logic [3:0]         digit_value;

   chbd_hex_digit u_hex (
      .char_in     (in_byte),
      .digit_valid (digit_valid),
      .digit_value (digit_value)
   );

   always_comb begin
      // new message restarts the decoder before this byte
      cur_phase   = new_message ? PH_SIZE : phase_ff;
      cur_rem     = new_message ? '0 : rem_ff;
      cur_seen    = new_message ? '0 : seen_ff;
      cur_stopped = new_message ? 1'b0 : stopped_ff;
      cur_drop    = new_message ? 2'd0 : drop_ff;

      phase_in    = cur_phase;
      rem_in      = cur_rem;
      seen_in     = cur_seen;
      stopped_in  = cur_stopped;
      drop_in     = cur_drop;
      res_valid   = 1'b0;
      kind_in     = chbd_pkg::KIND_BYTE;
      byte_in     = 8'd0;
      len_ctl.clear = new_message;
      len_ctl.incr  = 1'b0;

      unique case (cur_phase)
         PH_SIZE: begin
            if (in_byte == chbd_pkg::CHAR_CR || in_byte == chbd_pkg::CHAR_LF) begin
               phase_in = PH_AFTER;
            end else if (cur_seen < SEEN_W'(SIZE_CHARS)) begin
               seen_in = cur_seen + 1'b1;
               if (!cur_stopped) begin
                  if (digit_valid) begin
                     rem_in = (cur_rem << 4) | CNT_W'(digit_value);
                  end else begin
                     stopped_in = 1'b1;
                  end
               end
            end
         end
         PH_AFTER: begin
            if (cur_seen == '0) begin
               // empty size line
               phase_in  = PH_HALT;
               res_valid = 1'b1;
               kind_in   = chbd_pkg::KIND_ERROR;
            end else if (cur_rem == '0) begin
               // last chunk
               phase_in  = PH_HALT;
               res_valid = 1'b1;
               kind_in   = chbd_pkg::KIND_END;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            len_ctl.incr = 1'b1;
            rem_in       = cur_rem - 1'b1;
            res_valid    = 1'b1;
            byte_in      = in_byte;
            if (cur_rem == CNT_W'(1)) begin
               phase_in = PH_TRAILER;
               drop_in  = chbd_pkg::TRAILER_DROP;
            end
         end
         PH_TRAILER: begin
            if (cur_drop != 2'd0) begin
               drop_in = cur_drop - 1'b1;
            end
            if (cur_drop <= 2'd1) begin
               // back to a fresh size line
               phase_in   = PH_SIZE;
               rem_in     = '0;
               seen_in    = '0;
               stopped_in = 1'b0;
               drop_in    = 2'd0;
            end
         end
         default: begin
         end
      endcase

      len_in   = report_len;
      valid_in = valid_ff;
      if (accept) begin
         valid_in = res_valid;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SIZE;
         rem_ff     <= '0;
         seen_ff    <= '0;
         stopped_ff <= 1'b0;
         drop_ff    <= 2'd0;
         valid_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (accept) begin
            phase_ff   <= phase_in;
            rem_ff     <= rem_in;
            seen_ff    <= seen_in;
            stopped_ff <= stopped_in;
            drop_ff    <= drop_in;
         end
      end
      if (accept && res_valid) begin
         byte_ff <= byte_in;
         kind_ff <= kind_in;
         len_ff  <= len_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_body_length = len_ff;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the chunked body decoder: a cycle-free tracker of
// the framing predicts every payload, end and error result, and a monitor on
// the result channel compares each transaction in order
// ----------------------------------------------------------------------------
module tb;

   localparam int SIZE_CHARS  = 9;
   localparam int ITEM_TARGET = 1250;
   localparam int CYCLE_LIMIT = 400000;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_F  = 8'h46;
   localparam logic [7:0] CH_LOW_A = 8'h61;
   localparam logic [7:0] CH_LOW_F = 8'h66;
   localparam logic [7:0] CH_LOW_G = 8'h67;
   localparam logic [7:0] CH_LOW_Z = 8'h7A;
   localparam logic [7:0] CH_SEMI  = 8'h3B;

   typedef enum logic [2:0] {
      LINE_SIZE,
      LINE_AFTER,
      LINE_PAYLOAD,
      LINE_TRAILER,
      LINE_HALT
   } frame_phase_type;

   typedef struct packed {
      logic [7:0]         data;
      chbd_pkg::kind_type kind;
      logic [31:0]        length;
   } body_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'h00;
   logic        req_new_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic [1:0]  rsp_kind;
   logic [31:0] rsp_body_length;

   // framing tracker
   frame_phase_type fr_phase = LINE_SIZE;
   logic [63:0]  fr_remaining = '0;
   logic [3:0]   fr_seen = '0;
   bit           fr_stopped = 1'b0;
   logic [1:0]   fr_drops = '0;
   logic [31:0]  fr_total = '0;

   body_result_type awaited_results[$];
   logic [7:0]   body_q[$];

   int mismatches = 0;
   int items_counted = 0;
   int results_checked = 0;
   int payload_seen = 0;
   int ends_seen = 0;
   int errors_seen = 0;
   int cycles = 0;

   // sender burst control and receiver stall pattern
   int          idle_mode = 0;
   int          burst_left = 0;
   int          stall_mode = 0;
   logic [31:0] stall_bits = 32'hFFFF_FFFF;
   logic [4:0]  stall_ptr = '0;

   http_chunked_body_decoder #(
      .SIZE_CHARS(SIZE_CHARS),
      .LENGTH_BITS(32)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_in_byte(req_in_byte),
      .req_new_message(req_new_message),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_kind(rsp_kind),
      .rsp_body_length(rsp_body_length)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  awaited_results.size());
         $display("http_chunked_body_decoder test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tracker

   function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
      v = 4'h0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         v = 4'(c - CH_ZERO);
         return 1'b1;
      end
      if (c >= CH_LOW_A && c <= CH_LOW_F) begin
         v = 4'(c - CH_LOW_A + 8'd10);
         return 1'b1;
      end
      if (c >= CH_UP_A && c <= CH_UP_F) begin
         v = 4'(c - CH_UP_A + 8'd10);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic clear_size_line();
      fr_phase     = LINE_SIZE;
      fr_remaining = '0;
      fr_seen      = '0;
      fr_stopped   = 1'b0;
      fr_drops     = '0;
   endtask

   task automatic note_result(input logic [7:0] d, input chbd_pkg::kind_type k);
      body_result_type r;
      r.data   = d;
      r.kind   = k;
      r.length = fr_total;
      awaited_results.push_back(r);
   endtask

   task automatic track_body_byte(input logic [7:0] b, input logic nm);
      logic [3:0] nib;
      if (nm) begin
         clear_size_line();
         fr_total = '0;
      end
      case (fr_phase)
         LINE_SIZE: begin
            if (b == chbd_pkg::CHAR_CR || b == chbd_pkg::CHAR_LF) begin
               fr_phase = LINE_AFTER;
            end else if (fr_seen < SIZE_CHARS) begin
               fr_seen = fr_seen + 4'd1;
               if (!fr_stopped) begin
                  if (hex_nibble(b, nib))
                     fr_remaining = {fr_remaining[59:0], nib};
                  else
                     fr_stopped = 1'b1;
               end
            end
         end
         LINE_AFTER: begin
            // decision comes one byte after the terminator
            if (fr_seen == 0) begin
               fr_phase = LINE_HALT;
               note_result(8'h00, chbd_pkg::KIND_ERROR);
            end else if (fr_remaining == 0) begin
               fr_phase = LINE_HALT;
               note_result(8'h00, chbd_pkg::KIND_END);
            end else begin
               fr_phase = LINE_PAYLOAD;
            end
         end
         LINE_PAYLOAD: begin
            if (fr_total != 32'hFFFF_FFFF)
               fr_total = fr_total + 32'd1;
            fr_remaining = fr_remaining - 64'd1;
            if (fr_remaining == 0) begin
               fr_phase = LINE_TRAILER;
               fr_drops = chbd_pkg::TRAILER_DROP;
            end
            note_result(b, chbd_pkg::KIND_BYTE);
         end
         LINE_TRAILER: begin
            if (fr_drops > 0)
               fr_drops = fr_drops - 2'd1;
            if (fr_drops == 0)
               clear_size_line();
         end
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------- sender

   task automatic send_body_byte(input logic [7:0] b, input logic nm);
      int gap;
      if (idle_mode != 0 && burst_left == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0)
         burst_left--;
      req_valid       <= 1'b1;
      req_in_byte     <= b;
      req_new_message <= nm;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // halted bytes without a restart are only swallowed
      if (nm || fr_phase != LINE_HALT)
         items_counted++;
      track_body_byte(b, nm);
   endtask

   // sends up to limit bytes of the body under construction, then drops it
   task automatic send_body(input int limit);
      int n;
      n = body_q.size();
      if (limit < n)
         n = limit;
      for (int i = 0; i < n; i++)
         send_body_byte(body_q[i], i == 0);
      body_q.delete();
   endtask

   // ---------------------------------------------------------------- body builders

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++)
         body_q.push_back(s[i]);
   endtask

   task automatic add_hex_line(input logic [63:0] val, input int zeros);
      int          nd;
      logic [63:0] t;
      logic [3:0]  nib;
      nd = 1;
      t = val >> 4;
      while (t != 0) begin
         nd++;
         t = t >> 4;
      end
      repeat (zeros) body_q.push_back(CH_ZERO);
      for (int i = nd - 1; i >= 0; i--) begin
         nib = val[i*4 +: 4];
         if (nib < 10)
            body_q.push_back(CH_ZERO + nib);
         else if ($urandom_range(0, 1))
            body_q.push_back(CH_UP_A + nib - 8'd10);
         else
            body_q.push_back(CH_LOW_A + nib - 8'd10);
      end
   endtask

   // crlf mostly, a bare lf or cr followed by any byte otherwise
   task automatic add_terminator();
      int r;
      r = $urandom_range(0, 9);
      if (r < 8) begin
         body_q.push_back(chbd_pkg::CHAR_CR);
         body_q.push_back(chbd_pkg::CHAR_LF);
      end else begin
         body_q.push_back(r == 8 ? chbd_pkg::CHAR_LF : chbd_pkg::CHAR_CR);
         body_q.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic add_extension();
      body_q.push_back(CH_SEMI);
      repeat ($urandom_range(0, 3))
         body_q.push_back(8'($urandom_range(CH_LOW_G, CH_LOW_Z)));
   endtask

   task automatic add_chunk(input int size);
      add_hex_line(64'(size), $urandom_range(0, 2));
      if ($urandom_range(0, 4) == 0)
         add_extension();
      add_terminator();
      repeat (size) body_q.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) != 0) begin
         body_q.push_back(chbd_pkg::CHAR_CR);
         body_q.push_back(chbd_pkg::CHAR_LF);
      end else begin
         body_q.push_back(8'($urandom_range(0, 255)));
         body_q.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic add_end_line();
      case ($urandom_range(0, 3))
         0: add_hex_line(64'd0, $urandom_range(0, 3));
         1: body_q.push_back(8'($urandom_range(CH_LOW_G, CH_LOW_Z)));
         2: begin
            body_q.push_back(CH_ZERO);
            add_extension();
         end
         default: body_q.push_back(CH_ZERO);
      endcase
      add_terminator();
   endtask

   function automatic int chunk_size();
      if ($urandom_range(0, 9) != 0)
         return $urandom_range(1, 16);
      return $urandom_range(17, 300);
   endfunction

   // ---------------------------------------------------------------- tests

   // two bytes at the byte extremes, hex stopped by an extension, then the end
   task automatic test_basic_chunks();
      idle_mode  = 0;
      stall_mode = 0;
      add_text("2;\r\n");
      body_q.push_back(8'h00);
      body_q.push_back(8'hFF);
      add_text("\r\n0\r\n");
      send_body(body_q.size());
   endtask

   // empty line, a halted byte, a line with no hex digit, an overlong line
   // whose chunk is cut off in its trailer by the next restart
   task automatic test_size_line_cases();
      idle_mode  = 1;
      stall_mode = 2;
      add_text("\nZQ");
      send_body(body_q.size());
      add_text("g\r\n");
      send_body(body_q.size());
      add_text("000000001F\r\n");
      body_q.push_back(8'h5A);
      send_body(body_q.size());
   endtask

   task automatic test_random_bodies();
      int shape;
      int n;
      while (items_counted < ITEM_TARGET) begin
         idle_mode  = ($urandom_range(0, 3) != 0);
         stall_mode = $urandom_range(0, 3);
         shape = $urandom_range(0, 99);
         if (shape < 75) begin
            // chunks, then an end line that is mostly zero and at times a non-hex letter
            repeat ($urandom_range(0, 3)) add_chunk(chunk_size());
            add_end_line();
            repeat ($urandom_range(0, 3)) body_q.push_back(8'($urandom_range(0, 255)));
            send_body(body_q.size());
         end else if (shape < 85) begin
            // chunks followed by an empty size line
            repeat ($urandom_range(0, 2)) add_chunk($urandom_range(1, 16));
            add_terminator();
            repeat ($urandom_range(0, 2)) body_q.push_back(8'($urandom_range(0, 255)));
            send_body(body_q.size());
         end else if (shape < 92) begin
            // cut off anywhere, the next body restarts the decoder
            repeat ($urandom_range(1, 3)) add_chunk($urandom_range(1, 16));
            add_end_line();
            send_body($urandom_range(1, body_q.size()));
         end else if (shape < 95) begin
            // full-width size, only a few payload bytes before the cut
            add_hex_line({28'h0, 4'($urandom_range(1, 15)), 32'($urandom)}, 0);
            add_terminator();
            repeat ($urandom_range(3, 20)) body_q.push_back(8'($urandom_range(0, 255)));
            send_body(body_q.size());
         end else if (shape < 97) begin
            // overlong size line, the framing decides what follows
            add_hex_line(64'($urandom_range(0, 255)), $urandom_range(6, 12));
            add_terminator();
            repeat ($urandom_range(0, 12)) body_q.push_back(8'($urandom_range(0, 255)));
            add_text("0\r\n");
            send_body(body_q.size());
         end else begin
            // noise, biased toward framing characters
            n = $urandom_range(1, 20);
            repeat (n) begin
               case ($urandom_range(0, 5))
                  0: body_q.push_back(chbd_pkg::CHAR_CR);
                  1: body_q.push_back(chbd_pkg::CHAR_LF);
                  2: body_q.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
                  default: body_q.push_back(8'($urandom_range(0, 255)));
               endcase
            end
            send_body(body_q.size());
         end
      end
   endtask

   // ---------------------------------------------------------------- receiver

   always @(posedge clock) begin
      if (stall_mode == 0) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= stall_bits[stall_ptr];
         if (stall_ptr == 5'd31)
            stall_bits <= (stall_mode == 2) ? ($urandom & $urandom) : ($urandom | $urandom);
         stall_ptr <= stall_ptr + 5'd1;
      end
   end

   always @(posedge clock) begin : check_results
      body_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_results.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result: byte %h kind %0d length %0d", $time,
                     rsp_out_byte, rsp_kind, rsp_body_length);
         end else begin
            want = awaited_results.pop_front();
            results_checked++;
            case (want.kind)
               chbd_pkg::KIND_BYTE: payload_seen++;
               chbd_pkg::KIND_END:  ends_seen++;
               default:             errors_seen++;
            endcase
            if (rsp_out_byte !== want.data) begin
               mismatches++;
               $display("%0t: out_byte expected %h actual %h", $time, want.data,
                        rsp_out_byte);
            end
            if (rsp_kind !== want.kind) begin
               mismatches++;
               $display("%0t: kind expected %0d actual %0d", $time, want.kind, rsp_kind);
            end
            if (rsp_body_length !== want.length) begin
               mismatches++;
               $display("%0t: body_length expected %0d actual %0d", $time, want.length,
                        rsp_body_length);
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_chunks();
      test_size_line_cases();
      test_random_bodies();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (awaited_results.size() != 0) begin
         mismatches++;
         $display("%0t: %0d results never arrived", $time, awaited_results.size());
      end
      $display("decoded %0d body transactions across clean, truncated, overlong and noisy bodies",
               items_counted);
      $display("checked %0d results: %0d payload bytes, %0d end, %0d error; %0d mismatches",
               results_checked, payload_seen, ends_seen, errors_seen, mismatches);
      if (mismatches == 0)
         $display("http_chunked_body_decoder test passed");
      else
         $display("http_chunked_body_decoder test failed");
      $finish;
   end

endmodule
